// ===== hw/rtl/insertion_sorter_defines.svh =====
// Assertion helpers used by the sorter RTL.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Checked only outside reset.
`define ISORT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ISORT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/isort_pkg.sv =====
`default_nettype none
package isort_pkg;

    localparam int DATA_W = 32;

    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] data;
    } t_slot;

    typedef struct packed {
        logic                     insert;
        logic                     pop;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ===== hw/rtl/isort_in_if.sv =====
`default_nettype none
interface isort_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/isort_out_if.sv =====
`default_nettype none
interface isort_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/insertion_sorter.sv =====
// Channel  | Dir | Payload                              | Meaning
// i_in     | in  | value[31:0] s, last_in               | one element of a run
// o_out    | out | sorted_value[31:0] s, last_out, ovf  | run in ascending order
//
// On each accepted input request every cell compares against the new value
// and shifts right in the same cycle. After the last request the chain drains
// from its head, one result per cycle while o_out.ready is high, until all N
// stored values are emitted; input is held off until the last one is taken.
// Synchronous active-low reset empties the chain.
// Output stalls simply hold the chain; values beyond MAX_ITEMS are dropped.
`default_nettype none
`include "insertion_sorter_defines.svh"
module insertion_sorter
    import isort_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    isort_in_if.sink      i_in,
    isort_out_if.source   o_out
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    localparam logic ST_FILL  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_dropped;
    logic             n_dropped;

    t_cell_ctrl             w_ctrl;
    t_slot                  w_slot [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]   w_take;
    logic [MAX_ITEMS-1:0]   w_valid;
    logic                   w_in_acc;
    logic                   w_out_acc;
    logic                   w_full;

    assign w_full    = (r_count == CNT_W'(MAX_ITEMS));
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    assign w_ctrl.insert = w_in_acc && !w_full;
    assign w_ctrl.pop    = w_out_acc;
    assign w_ctrl.value  = i_in.value;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            t_slot w_left;
            t_slot w_right;
            logic  w_left_take;

            if (gi == 0) begin : g_head
                assign w_left      = '{valid: 1'b1, data: i_in.value};
                assign w_left_take = 1'b0;
            end else begin : g_body
                assign w_left      = w_slot[gi-1];
                assign w_left_take = w_take[gi-1];
            end

            if (gi == MAX_ITEMS - 1) begin : g_tail
                assign w_right = '{valid: 1'b0, data: '0};
            end else begin : g_inner
                assign w_right = w_slot[gi+1];
            end

            isort_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (w_ctrl),
                .i_left      (w_left),
                .i_left_take (w_left_take),
                .i_right     (w_right),
                .o_slot      (w_slot[gi]),
                .o_take      (w_take[gi])
            );

            assign w_valid[gi] = w_slot[gi].valid;
        end
    endgenerate

    assign i_in.ready         = (r_state == ST_FILL);
    assign o_out.valid        = (r_state == ST_DRAIN) && w_slot[0].valid;
    assign o_out.sorted_value = w_slot[0].data;
    assign o_out.last_out     = !w_slot[1].valid;
    assign o_out.overflow     = r_dropped;

    always_comb begin
        n_state   = r_state;
        n_dropped = r_dropped;
        n_count   = r_count;
        if (w_ctrl.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctrl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
        unique case (r_state)
            ST_FILL: begin
                if (w_in_acc && w_full) begin
                    n_dropped = 1'b1;
                end
                if (w_in_acc && i_in.last_in) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && o_out.last_out) begin
                    n_state   = ST_FILL;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    `ISORT_ASSERT(a_no_input_while_emit, i_clk, i_rst_n, o_out.valid |-> !i_in.ready, "input open while emitting")
    `ISORT_ASSERT(a_count_matches_cells, i_clk, i_rst_n, r_count == CNT_W'($countones(w_valid)), "fill count disagrees with occupied cells")
    `ISORT_ASSERT(a_cells_packed, i_clk, i_rst_n, $onehot({1'b0, w_valid} + {{MAX_ITEMS{1'b0}}, 1'b1}), "occupied cells not contiguous from head")
    `ISORT_ASSERT(a_run_ends_empty, i_clk, i_rst_n, (w_out_acc && o_out.last_out) |=> (r_count == '0 && !r_dropped && i_in.ready), "chain not empty after final result")
    `ISORT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!o_out.valid && r_count == '0), "output active right after reset")

endmodule
`default_nettype wire

// ===== hw/rtl/isort_cell.sv =====
`default_nettype none
module isort_cell
    import isort_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctrl i_ctrl,
    input  wire t_slot      i_left,
    input  wire logic       i_left_take,
    input  wire t_slot      i_right,
    output t_slot           o_slot,
    output logic            o_take
);

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_data;
    logic                     n_valid;
    logic signed [DATA_W-1:0] n_data;
    logic                     w_gt;

    // Strictly greater: equal values stay ahead of the newcomer.
    assign w_gt   = r_valid && (r_data > i_ctrl.value);
    assign o_take = w_gt || !r_valid;
    assign o_slot = '{valid: r_valid, data: r_data};

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.pop) begin
            // advance toward the head
            n_valid = i_right.valid;
            n_data  = i_right.data;
        end else if (i_ctrl.insert && o_take) begin
            // shift right, or take the new value where the gap opens
            n_valid = r_valid || i_left.valid;
            n_data  = i_left_take ? i_left.data : i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_data <= n_data;
    end

endmodule
`default_nettype wire
